FILE: rtl/core/csvft_pkg.sv
// csvft_pkg: types, character codes and escape decoding for the CSV field tokenizer.
// No dependencies; used by csv_field_tokenizer_top and csvft_checker.

package csvft_pkg;

  // Parser phases; codes not listed behave as PH_LEAD
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_UNQ   = 3'd1,
    PH_QUOT  = 3'd2,
    PH_QSEEN = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  // Field-end codes
  localparam logic [2:0] FEND_NL    = 3'd0;
  localparam logic [2:0] FEND_COMMA = 3'd1;
  localparam logic [2:0] FEND_SEMI  = 3'd2;
  localparam logic [2:0] FEND_TAB   = 3'd3;
  localparam logic [2:0] FEND_EOI   = 3'd4;

  // Delimiter select codes
  localparam logic [1:0] DSEL_TAB = 2'd3;

  // Register indexes
  localparam logic REG_DELIM  = 1'b0;
  localparam logic REG_MAXLEN = 1'b1;

  localparam logic [1:0]  DELIM_RST  = 2'd1;
  localparam logic [15:0] MAXLEN_RST = 16'd65534;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       ok;
    logic [7:0] val;
  } esc_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic [2:0] term_code;
    logic       truncated;
    logic       last;
  } res_t;

  function automatic logic [7:0] delim_char(input logic [1:0] sel);
    logic [7:0] c;
    case (sel)
      2'd0:    c = CH_LF;
      2'd1:    c = CH_COMMA;
      2'd2:    c = CH_SEMI;
      default: c = CH_TAB;
    endcase
    return c;
  endfunction

  function automatic esc_t decode_esc(input logic [7:0] b);
    esc_t e;
    e.ok  = 1'b1;
    e.val = b;
    case (b)
      8'h62:   e.val = CH_BS;   // b
      8'h66:   e.val = CH_FF;   // f
      8'h6E:   e.val = CH_LF;   // n
      8'h74:   e.val = CH_TAB;  // t
      8'h72:   e.val = CH_CR;   // r
      8'h76:   e.val = CH_VT;   // v
      CH_BSL:  e.val = CH_BSL;
      default: e.ok  = 1'b0;
    endcase
    return e;
  endfunction

endpackage

FILE: rtl/core/csv_field_tokenizer_top.sv
// csv_field_tokenizer_top: byte-at-a-time CSV field splitter with escape decoding.
// Depends on csvft_pkg.
//
// Results: each input beat's results are registered in the result queue and offered in order.
// Throughput: one input beat per cycle while each byte yields at most one result and
//   the result side is not stalled; the single result port moves one beat per cycle,
//   so bytes yielding two results (stray escape, end of input after a backslash)
//   fill the queue faster than it drains. A four-entry result queue decouples the
//   sides; input is taken while it has room for two entries.
// Reset: rst_n synchronous, active low; clears phase, escape flag, byte count and
//   queue, and sets delimiter_select to comma and max_field_bytes to 65534.

module csv_field_tokenizer_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_end_of_input,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_byte,
  output logic        out_is_data,
  output logic [2:0]  out_terminator_code,
  output logic        out_truncated,
  output logic        out_last_of_item,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers. Only paddr[2] selects the register; low bits ignored.
  // ---------------------------------------------------------------------------
  logic [1:0]  delim_sel_r;
  logic [15:0] max_bytes_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_sel_r <= csvft_pkg::DELIM_RST;
      max_bytes_r <= csvft_pkg::MAXLEN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == csvft_pkg::REG_DELIM) begin
        delim_sel_r <= pwdata[1:0];
      end else begin
        max_bytes_r <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == csvft_pkg::REG_DELIM) begin
      prdata = {30'd0, delim_sel_r};
    end else begin
      prdata = {16'd0, max_bytes_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------------
  csvft_pkg::phase_t phase_r, phase_nxt;
  logic              bs_r, bs_nxt;     // backslash seen, awaiting next byte
  logic [15:0]       cnt_r, cnt_nxt;   // content bytes emitted in this field

  // Result queue
  csvft_pkg::res_t              q_r [csvft_pkg::QDEPTH];
  logic [csvft_pkg::QAW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [csvft_pkg::QCW-1:0]    q_cnt_r;

  logic accept, pop;

  assign in_ready  = (q_cnt_r <= csvft_pkg::QCW'(csvft_pkg::QDEPTH - 2));
  assign accept    = in_valid & in_ready;
  assign out_valid = (q_cnt_r != '0);
  assign pop       = out_valid & out_ready;

  // ---------------------------------------------------------------------------
  // Per-byte decision. A byte causes up to: a stray backslash (pd), one content
  // byte (md) or a field close (cl). md and cl never occur together.
  // ---------------------------------------------------------------------------
  csvft_pkg::esc_t esc;
  logic [7:0]      delim;
  logic            pd_req, md_req, cl_req, norm;
  logic [7:0]      md_byte;
  logic [2:0]      cl_code;
  logic            trail_skip;
  logic [2:0]      trail_code;

  assign esc   = csvft_pkg::decode_esc(in_byte);
  assign delim = csvft_pkg::delim_char(delim_sel_r);

  // After a closing quote: space and non-delimiter tab skip; comma, semicolon, tab
  // close with own code whatever the delimiter; else swallowed, closes as newline.
  assign trail_skip = (in_byte == csvft_pkg::CH_SPACE) ||
                      ((in_byte == csvft_pkg::CH_TAB) && (delim_sel_r != csvft_pkg::DSEL_TAB));
  always_comb begin
    if (in_byte == csvft_pkg::CH_COMMA) begin
      trail_code = csvft_pkg::FEND_COMMA;
    end else if (in_byte == csvft_pkg::CH_SEMI) begin
      trail_code = csvft_pkg::FEND_SEMI;
    end else if (in_byte == csvft_pkg::CH_TAB) begin
      trail_code = csvft_pkg::FEND_TAB;
    end else begin
      trail_code = csvft_pkg::FEND_NL;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    bs_nxt    = bs_r;
    pd_req    = 1'b0;
    md_req    = 1'b0;
    md_byte   = in_byte;
    cl_req    = 1'b0;
    cl_code   = csvft_pkg::FEND_NL;
    norm      = 1'b1;
    if (in_end_of_input) begin
      // a dangling backslash inside a field is content
      pd_req  = bs_r && ((phase_r == csvft_pkg::PH_UNQ) || (phase_r == csvft_pkg::PH_QUOT));
      cl_req  = 1'b1;
      cl_code = csvft_pkg::FEND_EOI;
    end else begin
      case (phase_r)
        csvft_pkg::PH_UNQ, csvft_pkg::PH_QUOT: begin
          if (bs_r) begin
            bs_nxt = 1'b0;
            if (esc.ok) begin
              md_req  = 1'b1;
              md_byte = esc.val;
              norm    = 1'b0;
            end else begin
              // unknown escape: emit the backslash, then treat the byte alone
              pd_req = 1'b1;
            end
          end
          if (norm) begin
            if (phase_r == csvft_pkg::PH_UNQ) begin
              if (in_byte == csvft_pkg::CH_LF) begin
                cl_req  = 1'b1;
                cl_code = csvft_pkg::FEND_NL;
              end else if (in_byte == delim) begin
                cl_req  = 1'b1;
                cl_code = {1'b0, delim_sel_r};
              end else if (in_byte == csvft_pkg::CH_BSL) begin
                bs_nxt = 1'b1;
              end else begin
                md_req = 1'b1;
              end
            end else begin
              if (in_byte == csvft_pkg::CH_QUOTE) begin
                phase_nxt = csvft_pkg::PH_QSEEN;
              end else if (in_byte == csvft_pkg::CH_BSL) begin
                bs_nxt = 1'b1;
              end else begin
                md_req = 1'b1;
              end
            end
          end
        end
        csvft_pkg::PH_QSEEN: begin
          if (in_byte == csvft_pkg::CH_QUOTE) begin
            md_req    = 1'b1;   // doubled quote
            phase_nxt = csvft_pkg::PH_QUOT;
          end else if (trail_skip) begin
            phase_nxt = csvft_pkg::PH_TRAIL;
          end else begin
            cl_req  = 1'b1;
            cl_code = trail_code;
          end
        end
        csvft_pkg::PH_TRAIL: begin
          if (trail_skip) begin
            phase_nxt = csvft_pkg::PH_TRAIL;
          end else begin
            cl_req  = 1'b1;
            cl_code = trail_code;
          end
        end
        default: begin
          // leading blank skip; delimiter is tested before the blanks
          phase_nxt = csvft_pkg::PH_LEAD;
          bs_nxt    = 1'b0;
          if (in_byte == csvft_pkg::CH_LF) begin
            cl_req  = 1'b1;
            cl_code = csvft_pkg::FEND_NL;
          end else if (in_byte == delim) begin
            cl_req  = 1'b1;
            cl_code = {1'b0, delim_sel_r};
          end else if ((in_byte == csvft_pkg::CH_SPACE) || (in_byte == csvft_pkg::CH_CR) ||
                       (in_byte == csvft_pkg::CH_TAB)) begin
            phase_nxt = csvft_pkg::PH_LEAD;
          end else if (in_byte == csvft_pkg::CH_QUOTE) begin
            phase_nxt = csvft_pkg::PH_QUOT;
          end else if (in_byte == csvft_pkg::CH_BSL) begin
            phase_nxt = csvft_pkg::PH_UNQ;
            bs_nxt    = 1'b1;
          end else begin
            phase_nxt = csvft_pkg::PH_UNQ;
            md_req    = 1'b1;
          end
        end
      endcase
    end
    if (cl_req) begin
      phase_nxt = csvft_pkg::PH_LEAD;
      bs_nxt    = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Length limit and result assembly
  // ---------------------------------------------------------------------------
  logic [15:0] limit, cnt_mid, cnt_end;
  logic        pd_emit, md_emit, trunc;
  logic [1:0]  n_res;
  csvft_pkg::res_t r_pd, r_md, r_cl, e0, e1;

  assign limit   = (max_bytes_r == 16'd0) ? 16'd1 : max_bytes_r;
  assign pd_emit = pd_req && (cnt_r < limit);
  assign cnt_mid = cnt_r + {15'd0, pd_emit};
  assign md_emit = md_req && (cnt_mid < limit);
  assign cnt_end = cnt_mid + {15'd0, md_emit};
  assign trunc   = (cnt_end >= limit);
  assign cnt_nxt = cl_req ? 16'd0 : cnt_end;
  assign n_res   = {1'b0, pd_emit} + {1'b0, md_emit} + {1'b0, cl_req};

  always_comb begin
    r_pd = '{data_byte: csvft_pkg::CH_BSL, is_data: 1'b1, term_code: csvft_pkg::FEND_NL,
             truncated: 1'b0, last: 1'b0};
    r_md = '{data_byte: md_byte, is_data: 1'b1, term_code: csvft_pkg::FEND_NL,
             truncated: 1'b0, last: 1'b0};
    r_cl = '{data_byte: 8'd0, is_data: 1'b0, term_code: cl_code,
             truncated: trunc, last: 1'b0};
    if (pd_emit) begin
      e0 = r_pd;
    end else if (md_emit) begin
      e0 = r_md;
    end else begin
      e0 = r_cl;
    end
    e1      = (pd_emit && md_emit) ? r_md : r_cl;
    e0.last = (n_res == 2'd1);
    e1.last = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // State and queue registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= csvft_pkg::PH_LEAD;
      bs_r     <= 1'b0;
      cnt_r    <= 16'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      if (accept) begin
        phase_r  <= phase_nxt;
        bs_r     <= bs_nxt;
        cnt_r    <= cnt_nxt;
        wr_ptr_r <= wr_ptr_r + csvft_pkg::QAW'(n_res);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + csvft_pkg::QAW'(1);
      end
      q_cnt_r <= q_cnt_r + (accept ? csvft_pkg::QCW'(n_res) : '0)
                         - (pop ? csvft_pkg::QCW'(1) : '0);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (accept && (n_res != 2'd0)) begin
      q_r[wr_ptr_r] <= e0;
    end
    if (accept && (n_res == 2'd2)) begin
      q_r[wr_ptr_r + csvft_pkg::QAW'(1)] <= e1;
    end
  end

  assign out_data_byte       = q_r[rd_ptr_r].data_byte;
  assign out_is_data         = q_r[rd_ptr_r].is_data;
  assign out_terminator_code = q_r[rd_ptr_r].term_code;
  assign out_truncated       = q_r[rd_ptr_r].truncated;
  assign out_last_of_item    = q_r[rd_ptr_r].last;

endmodule

FILE: rtl/core/csvft_checker.sv
// csvft_checker: port-level assertions for csv_field_tokenizer_top, bound in below.
// Depends on csvft_pkg.

module csvft_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_is_data,
  input logic [2:0] out_terminator_code,
  input logic       out_truncated,
  input logic       out_last_of_item
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) &&
      $stable(out_is_data) && $stable(out_terminator_code) && $stable(out_last_of_item))
    else $error("result beat changed while stalled");

  // a field end is always the last result of its byte
  a_close_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_data |-> out_last_of_item)
    else $error("field end not marked last");

  // content beats carry no terminator and no truncation flag
  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_data |-> (out_terminator_code == csvft_pkg::FEND_NL) && !out_truncated)
    else $error("content beat with terminator fields set");

  // input is only held off while results are queued
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result queue");

endmodule

bind csv_field_tokenizer_top csvft_checker u_csvft_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for csv_field_tokenizer_top: directed CSV text, then random record
// streams under several delimiter and field length settings. Depends on csvft_pkg.

`timescale 1ns / 1ps

module testbench;

  // Delimiter select values not named in the package
  localparam logic [1:0] DSEL_NL    = 2'd0;
  localparam logic [1:0] DSEL_COMMA = 2'd1;
  localparam logic [1:0] DSEL_SEMI  = 2'd2;

  // Delimiter byte for each select value, lowest byte is select 0
  localparam logic [31:0] DELIM_TABLE = {csvft_pkg::CH_TAB, csvft_pkg::CH_SEMI,
                                         csvft_pkg::CH_COMMA, csvft_pkg::CH_LF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'd0;
  logic        in_end_of_input = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_is_data;
  logic [2:0]  out_terminator_code;
  logic        out_truncated;
  logic        out_last_of_item;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  csv_field_tokenizer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte             (in_byte),
    .in_end_of_input     (in_end_of_input),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_data_byte       (out_data_byte),
    .out_is_data         (out_is_data),
    .out_terminator_code (out_terminator_code),
    .out_truncated       (out_truncated),
    .out_last_of_item    (out_last_of_item),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tokenizer mirror: phase, pending backslash, byte count and register copies
  // ---------------------------------------------------------------------------
  csvft_pkg::phase_t tok_phase = csvft_pkg::PH_LEAD;
  logic              tok_escape = 1'b0;
  logic [15:0]       tok_count = 16'd0;
  logic [1:0]        cfg_delim_sel = csvft_pkg::DELIM_RST;
  logic [15:0]       cfg_max_len = csvft_pkg::MAXLEN_RST;

  csvft_pkg::res_t step_tokens[$];      // results of the beat being predicted
  csvft_pkg::res_t expected_tokens[$];  // results still owed by the block, oldest first

  int  fail_count = 0;
  int  items_sent = 0;
  bit  no_stall = 1'b0;      // set for stretches without any idling

  // A limit of zero behaves as one
  function automatic logic [15:0] field_limit();
    return (cfg_max_len == 16'd0) ? 16'd1 : cfg_max_len;
  endfunction

  // Content bytes past the limit are silently dropped
  function automatic void emit_content(input logic [7:0] b);
    csvft_pkg::res_t r;
    if (tok_count < field_limit()) begin
      tok_count++;
      r = '0;
      r.data_byte = b;
      r.is_data = 1'b1;
      step_tokens.push_back(r);
    end
  endfunction

  function automatic void close_field(input logic [2:0] code);
    csvft_pkg::res_t r;
    r = '0;
    r.term_code = code;
    r.truncated = (tok_count >= field_limit());
    step_tokens.push_back(r);
    tok_phase = csvft_pkg::PH_LEAD;
    tok_escape = 1'b0;
    tok_count = 16'd0;
  endfunction

  // Resolves a pending backslash; returns 1 when the byte was swallowed by it.
  // An unknown escape gives a literal backslash and the byte is then parsed alone.
  function automatic logic resolve_escape(input logic [7:0] b);
    logic [7:0] v;
    logic       known;
    if (!tok_escape) return 1'b0;
    tok_escape = 1'b0;
    known = 1'b1;
    case (b)
      "b":     v = csvft_pkg::CH_BS;
      "f":     v = csvft_pkg::CH_FF;
      "n":     v = csvft_pkg::CH_LF;
      "t":     v = csvft_pkg::CH_TAB;
      "r":     v = csvft_pkg::CH_CR;
      "v":     v = csvft_pkg::CH_VT;
      csvft_pkg::CH_BSL: v = csvft_pkg::CH_BSL;
      default: begin
        v = csvft_pkg::CH_BSL;
        known = 1'b0;
      end
    endcase
    emit_content(v);
    return known;
  endfunction

  // After a closing quote the terminator is judged by its own byte, not the delimiter
  function automatic void trail_byte(input logic [7:0] b);
    if (b == csvft_pkg::CH_SPACE ||
        (b == csvft_pkg::CH_TAB && cfg_delim_sel != csvft_pkg::DSEL_TAB))
      tok_phase = csvft_pkg::PH_TRAIL;
    else if (b == csvft_pkg::CH_COMMA) close_field(csvft_pkg::FEND_COMMA);
    else if (b == csvft_pkg::CH_SEMI) close_field(csvft_pkg::FEND_SEMI);
    else if (b == csvft_pkg::CH_TAB) close_field(csvft_pkg::FEND_TAB);
    else close_field(csvft_pkg::FEND_NL);
  endfunction

  // Predicts the results of one accepted input beat and queues them
  function automatic void tokenize_byte(input logic [7:0] b, input logic eoi);
    logic [7:0]      delim;
    csvft_pkg::res_t r;
    delim = DELIM_TABLE[cfg_delim_sel*8 +: 8];
    step_tokens.delete();
    if (eoi) begin
      if (tok_escape && (tok_phase == csvft_pkg::PH_UNQ || tok_phase == csvft_pkg::PH_QUOT))
        emit_content(csvft_pkg::CH_BSL);
      close_field(csvft_pkg::FEND_EOI);
    end else begin
      case (tok_phase)
        csvft_pkg::PH_UNQ: begin
          if (!resolve_escape(b)) begin
            if (b == csvft_pkg::CH_LF) close_field(csvft_pkg::FEND_NL);
            else if (b == delim) close_field({1'b0, cfg_delim_sel});
            else if (b == csvft_pkg::CH_BSL) tok_escape = 1'b1;
            else emit_content(b);
          end
        end
        csvft_pkg::PH_QUOT: begin
          if (!resolve_escape(b)) begin
            if (b == csvft_pkg::CH_QUOTE) tok_phase = csvft_pkg::PH_QSEEN;
            else if (b == csvft_pkg::CH_BSL) tok_escape = 1'b1;
            else emit_content(b);
          end
        end
        csvft_pkg::PH_QSEEN: begin
          if (b == csvft_pkg::CH_QUOTE) begin
            emit_content(csvft_pkg::CH_QUOTE);
            tok_phase = csvft_pkg::PH_QUOT;
          end else begin
            trail_byte(b);
          end
        end
        csvft_pkg::PH_TRAIL: trail_byte(b);
        default: begin
          tok_phase = csvft_pkg::PH_LEAD;
          tok_escape = 1'b0;
          if (b == csvft_pkg::CH_LF) close_field(csvft_pkg::FEND_NL);
          else if (b == delim) close_field({1'b0, cfg_delim_sel});
          else if (b == csvft_pkg::CH_SPACE || b == csvft_pkg::CH_CR ||
                   b == csvft_pkg::CH_TAB) begin
            // leading blank, skipped
          end else if (b == csvft_pkg::CH_QUOTE) tok_phase = csvft_pkg::PH_QUOT;
          else if (b == csvft_pkg::CH_BSL) begin
            tok_phase = csvft_pkg::PH_UNQ;
            tok_escape = 1'b1;
          end else begin
            tok_phase = csvft_pkg::PH_UNQ;
            emit_content(b);
          end
        end
      endcase
    end
    foreach (step_tokens[i]) begin
      r = step_tokens[i];
      r.last = (i == step_tokens.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int draw_gap();
    int r;
    if (no_stall) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Random byte biased towards the characters the parser cares about
  function automatic logic [7:0] content_byte();
    string set;
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61 + 8'($urandom_range(0, 25));
      3: begin
        set = " \r\t";
        return set[$urandom_range(0, 2)];
      end
      4: begin
        set = ",;\t\n";
        return set[$urandom_range(0, 3)];
      end
      5:       return csvft_pkg::CH_BSL;
      6:       return csvft_pkg::CH_QUOTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One input beat; the prediction is made at the edge that accepts it.
  // Valid stays up across back-to-back beats and is lowered only for a gap.
  task automatic send_beat(input logic [7:0] b, input logic eoi);
    int gap;
    in_byte <= b;
    in_end_of_input <= eoi;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(b, eoi);
    items_sent++;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Drops valid, waits for every owed result, then lets the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write then read back of the same register; block must be idle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == csvft_pkg::REG_DELIM) begin
      cfg_delim_sel = value[1:0];
      want = {30'd0, value[1:0]};
    end else begin
      cfg_max_len = value[15:0];
      want = {16'd0, value[15:0]};
    end
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("register readback", want, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // One field of a record: optional leading blanks, unquoted, quoted or empty body,
  // then a terminator that is usually the delimiter or a newline
  task automatic send_field();
    string      blanks;
    string      esc_set;
    string      quote_terms;
    logic [7:0] c;
    logic [7:0] delim;
    int         kind;
    int         len;
    blanks = " \r\t";
    esc_set = "bfntrv\\";
    quote_terms = ",;\t";
    delim = DELIM_TABLE[cfg_delim_sel*8 +: 8];
    repeat ($urandom_range(0, 2)) send_beat(blanks[$urandom_range(0, 2)], 1'b0);
    kind = $urandom_range(0, 3);   // 0,1 unquoted, 2 quoted, 3 empty
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(0, 5);
    if (kind == 2) send_beat(csvft_pkg::CH_QUOTE, 1'b0);
    if (kind != 3) begin
      repeat (len) begin
        c = content_byte();
        if (kind == 2 && c == csvft_pkg::CH_QUOTE) begin
          send_beat(csvft_pkg::CH_QUOTE, 1'b0);   // doubled quote
        end else if (kind != 2 && (c == csvft_pkg::CH_LF || c == delim) &&
                     $urandom_range(0, 9) != 0) begin
          c = "x";
        end
        if (c == csvft_pkg::CH_BSL) begin
          send_beat(csvft_pkg::CH_BSL, 1'b0);
          c = ($urandom_range(0, 4) != 0) ? esc_set[$urandom_range(0, 6)] : content_byte();
        end
        send_beat(c, 1'b0);
      end
    end
    if (kind == 2) begin
      send_beat(csvft_pkg::CH_QUOTE, 1'b0);
      repeat ($urandom_range(0, 2)) send_beat(csvft_pkg::CH_SPACE, 1'b0);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: c = delim;
      6, 7:             c = csvft_pkg::CH_LF;
      8:                c = quote_terms[$urandom_range(0, 2)];
      default:          c = 8'($urandom_range(0, 255));
    endcase
    send_beat(c, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (comma, long limit): blank skipping, extreme bytes, empty fields,
  // and end of input straight after a field end
  task automatic test_blanks_and_empty_fields();
    no_stall = 1'b0;
    send_text(" \r\tA");
    send_beat(8'hFF, 1'b0);
    send_beat(8'h00, 1'b0);
    send_text(",,\n");
    send_beat(8'h00, 1'b1);
    wait_idle();
  endtask

  // Doubled quote, blanks after the closing quote, semicolon closing under comma
  // delimiter, and a stray escape whose quote closes the quoted field
  task automatic test_quoted_fields();
    no_stall = 1'b0;
    send_text("\"a\"\"\" \t;");
    send_text("\"\\\"z");
    wait_idle();
  endtask

  // Escape from the first byte, escaped backslash, unknown escape, and end of input
  // with a backslash still pending
  task automatic test_escapes();
    no_stall = 1'b0;
    send_text("\\n\\\\\\q\\");
    send_beat(8'hFF, 1'b1);
    wait_idle();
  endtask

  // Random record streams under one delimiter and length setting; most beats form
  // proper fields, the rest are stray bytes and end-of-input marks
  task automatic test_random_records(input logic [1:0] sel, input logic [15:0] max_len,
                                     input int count);
    int start;
    write_reg(csvft_pkg::REG_DELIM, {30'd0, sel});
    write_reg(csvft_pkg::REG_MAXLEN, {16'd0, max_len});
    no_stall = ($urandom_range(0, 3) == 0);
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(0, 19))
        0, 1:    send_beat(8'($urandom_range(0, 255)), 1'b0);
        2:       send_beat(8'($urandom_range(0, 255)), 1'b1);
        default: send_field();
      endcase
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random back-pressure and the checker
  // ---------------------------------------------------------------------------
  int stall_left = 0;

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= draw_gap();
    end
  end

  // Every accepted result beat is matched against the oldest owed one
  always @(posedge clk) begin : result_check
    csvft_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("result beat with nothing expected: is_data %0d data_byte %0d",
               out_is_data, out_data_byte);
        fail_count++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("data_byte", want.data_byte, out_data_byte);
        check_field("is_data", want.is_data, out_is_data);
        check_field("terminator_code", want.term_code, out_terminator_code);
        check_field("truncated", want.truncated, out_truncated);
        check_field("last_of_item", want.last, out_last_of_item);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_all
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_blanks_and_empty_fields();
    test_quoted_fields();
    test_escapes();

    // limit extremes (0 acts as 1, 65535) and both delimiter extremes
    test_random_records(DSEL_NL, 16'd1, 135);
    test_random_records(csvft_pkg::DSEL_TAB, 16'd0, 135);
    test_random_records(DSEL_SEMI, 16'hFFFF, 135);
    test_random_records(DSEL_COMMA, 16'd3, 135);
    test_random_records(csvft_pkg::DSEL_TAB, 16'd5, 135);
    test_random_records(2'($urandom_range(0, 3)), 16'($urandom_range(1, 8)), 135);
    test_random_records(DSEL_COMMA, csvft_pkg::MAXLEN_RST, 135);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
